>>> sv/current_pid_with_antiwindup_defines.svh
// ----------------------------------------------------------------------------
// Current PID assertion macros
// Shared assertion wrappers for the current controller RTL.
// ----------------------------------------------------------------------------
`ifndef CURRENT_PID_WITH_ANTIWINDUP_DEFINES_SVH
`define CURRENT_PID_WITH_ANTIWINDUP_DEFINES_SVH

// Checked only while out of reset.
`define CPWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPWA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/cpwa_pkg.sv
// ----------------------------------------------------------------------------
// Current PID package
// Types, constants and saturating helpers shared by the controller RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package cpwa_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SCALE_W  = 31;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DUTY_W   = 9;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned FRAC_W   = 16;

  // Digit-serial multiplier geometry.
  localparam int unsigned DIG_W    = 8;
  localparam int unsigned N_DIG    = DATA_W / DIG_W;
  localparam int unsigned CNT_W    = $clog2(N_DIG);
  localparam int unsigned LOW_W    = DATA_W - DIG_W;
  localparam int unsigned PP_W     = DATA_W + DIG_W + 1;
  localparam int unsigned SUM_W    = PP_W + 1;
  localparam int unsigned ACC_W    = SUM_W - DIG_W;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 9'd350;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_FB_SCALE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDUP_GAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_LEVEL_MAX   = 3'd5;
  localparam logic [IDX_W-1:0] REG_LEVEL_MIN   = 3'd6;
  localparam logic [IDX_W-1:0] REG_DUTY_SCALE  = 3'd7;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        [SCALE_W-1:0] feedback_scale;
    logic signed [DATA_W-1:0]  prop_gain;
    logic signed [DATA_W-1:0]  integ_gain;
    logic signed [DATA_W-1:0]  windup_gain;
    logic signed [DATA_W-1:0]  deriv_gain;
    logic signed [DATA_W-1:0]  level_max;
    logic signed [DATA_W-1:0]  level_min;
    logic        [SCALE_W-1:0] duty_scale;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB,
    ST_UP,
    ST_KI,
    ST_KC,
    ST_KD,
    ST_CLAMP,
    ST_DUTY,
    ST_FIN
  } state_e;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? S32_MIN : S32_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? S32_MIN : S32_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // Full product saturated to 32 bits, no shift.
  function automatic logic signed [DATA_W-1:0] sat_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-DATA_W:0] top;
    top = p[PROD_W-1:DATA_W-1];
    if (top != '0 && top != '1) begin
      return p[PROD_W-1] ? S32_MIN : S32_MAX;
    end
    return p[DATA_W-1:0];
  endfunction

  // Q16.16 product: floor shift by 16, then saturate.
  function automatic logic signed [DATA_W-1:0] sat_q16(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-DATA_W-FRAC_W:0] top;
    top = p[PROD_W-1:DATA_W+FRAC_W-1];
    if (top != '0 && top != '1) begin
      return p[PROD_W-1] ? S32_MIN : S32_MAX;
    end
    return p[DATA_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

>>> sv/cpwa_in_if.sv
// ----------------------------------------------------------------------------
// Current PID input channel
// Valid/ready channel carrying the setpoint and the raw ADC sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpwa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cpwa_pkg::DATA_W-1:0]   current_target;
  logic        [cpwa_pkg::SAMPLE_W-1:0] current_sample;

  modport source (
    output valid,
    output current_target,
    output current_sample,
    input  ready
  );

  modport sink (
    input  valid,
    input  current_target,
    input  current_sample,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/cpwa_out_if.sv
// ----------------------------------------------------------------------------
// Current PID result channel
// Valid/ready channel carrying the duty count, drive level and clamp flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpwa_out_if;
  logic                               valid;
  logic                               ready;
  logic        [cpwa_pkg::DUTY_W-1:0] duty_count;
  logic signed [cpwa_pkg::DATA_W-1:0] drive_level;
  logic                               clamped;

  modport source (
    output valid,
    output duty_count,
    output drive_level,
    output clamped,
    input  ready
  );

  modport sink (
    input  valid,
    input  duty_count,
    input  drive_level,
    input  clamped,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/cpwa_cfg.sv
// ----------------------------------------------------------------------------
// Current PID configuration registers
// Write-only register file for gains, scales and clamp limits.
// ----------------------------------------------------------------------------
`default_nettype none

module cpwa_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         we_i,
  input  wire logic [cpwa_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [cpwa_pkg::DATA_W-1:0]  wdata_i,
  output cpwa_pkg::cfg_t                    cfg_o
);
  import cpwa_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_FB_SCALE:    cfg_d.feedback_scale = wdata_i[SCALE_W-1:0];
        REG_PROP_GAIN:   cfg_d.prop_gain      = wdata_i;
        REG_INTEG_GAIN:  cfg_d.integ_gain     = wdata_i;
        REG_WINDUP_GAIN: cfg_d.windup_gain    = wdata_i;
        REG_DERIV_GAIN:  cfg_d.deriv_gain     = wdata_i;
        REG_LEVEL_MAX:   cfg_d.level_max      = wdata_i;
        REG_LEVEL_MIN:   cfg_d.level_min      = wdata_i;
        REG_DUTY_SCALE:  cfg_d.duty_scale     = wdata_i[SCALE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_scale <= 31'd66;
      cfg_q.prop_gain      <= 32'sd6554;
      cfg_q.integ_gain     <= 32'sd6554;
      cfg_q.windup_gain    <= 32'sd65536;
      cfg_q.deriv_gain     <= 32'sd0;
      cfg_q.level_max      <= 32'sd655360;
      cfg_q.level_min      <= 32'sd0;
      cfg_q.duty_scale     <= 31'd2293760;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/cpwa_mul.sv
// ----------------------------------------------------------------------------
// Current PID digit-serial multiplier
// Signed 32x32 multiply, one 8-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpwa_mul (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cpwa_pkg::mul_req_t  req_i,
  output cpwa_pkg::mul_rsp_t       rsp_o
);
  import cpwa_pkg::*;

  logic                     busy_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     done_q;
  logic signed [DATA_W-1:0] a_q;
  logic [DATA_W-1:0]        b_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [LOW_W-1:0]         low_q;
  logic signed [PROD_W-1:0] prod_q;

  logic                     last;
  logic signed [DIG_W:0]    dig;
  logic signed [PP_W-1:0]   pp;
  logic signed [SUM_W-1:0]  sum;

  // Top digit carries the sign of the multiplier.
  assign last = (cnt_q == CNT_W'(N_DIG - 1));
  assign dig  = last ? {b_q[DIG_W-1], b_q[DIG_W-1:0]} : {1'b0, b_q[DIG_W-1:0]};
  assign pp   = a_q * dig;
  assign sum  = {{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q} + {pp[PP_W-1], pp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      // Retire the low digit, advance the multiplier by one digit.
      acc_q <= sum[SUM_W-1:DIG_W];
      low_q <= {sum[DIG_W-1:0], low_q[LOW_W-1:DIG_W]};
      b_q   <= b_q >> DIG_W;
      if (last) begin
        prod_q <= {sum[DATA_W+DIG_W-1:0], low_q};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

`default_nettype wire

>>> sv/current_pid_with_antiwindup.sv
// ----------------------------------------------------------------------------
// Current PID controller with anti-windup
// Q16.16 current loop: feedback scaling, PID terms with integral correction,
// output clamp and PWM duty conversion, on one digit-serial multiplier.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            payload
//   in_i      in    valid / ready        current_target, current_sample
//   res_o     out   valid / ready        duty_count, drive_level, clamped
//   cfg       in    cfg_we_i (no stall)  cfg_idx_i, cfg_wdata_i
//
// One item at a time: after each result load the sequencer returns to idle
// before it accepts a new transfer. Six products share the digit-serial
// multiplier, each step passing through issue, four 8-bit digits and result,
// plus a clamp step and a load step.
// Input ready is high only while idle; the next item is taken while a
// finished result waits in the output register. A stalled result holds the
// sequencer in its final step until the slot frees. Reset clears the loop
// state (integral, saturation difference, previous P term) and loads the
// register defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "current_pid_with_antiwindup_defines.svh"

module current_pid_with_antiwindup (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  cpwa_in_if.sink                           in_i,
  cpwa_out_if.source                        res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [cpwa_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cpwa_pkg::DATA_W-1:0]  cfg_wdata_i
);
  import cpwa_pkg::*;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  state_e state_q, state_d;
  logic   go_q, go_d;

  // Item payload and intermediate terms.
  logic signed [DATA_W-1:0]  target_q;
  logic [SAMPLE_W-1:0]       count_q;
  logic signed [DATA_W-1:0]  err_q;
  logic signed [DATA_W-1:0]  up_q;
  logic signed [DATA_W-1:0]  diff_q;
  logic signed [DATA_W-1:0]  s1_q;
  logic signed [DATA_W-1:0]  pre_q;
  logic signed [DATA_W-1:0]  lvl_q;
  logic                      clip_q;

  // Controller state carried between items.
  logic signed [DATA_W-1:0]  integ_q;
  logic signed [DATA_W-1:0]  satd_q;
  logic signed [DATA_W-1:0]  prev_q;

  // Result register.
  logic                      out_valid_q;
  logic [DUTY_W-1:0]         duty_q;
  logic signed [DATA_W-1:0]  level_q;
  logic                      clamped_q;

  logic signed [DATA_W-1:0]  prod_q16;
  logic signed [DATA_W-1:0]  prod_sat;
  logic [DATA_W-1:0]         prod_hi;
  logic                      prod_pos;
  logic [DUTY_W-1:0]         duty_d;
  logic signed [DATA_W-1:0]  lvl_d;
  logic                      clip_d;
  logic                      in_xfer;
  logic                      out_load;
  logic                      mul_step;

  cpwa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  cpwa_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);
  assign mul_step   = state_q inside {ST_FB, ST_UP, ST_KI, ST_KC, ST_KD, ST_DUTY};

  // Product post-processing.
  assign prod_q16 = sat_q16(mul_rsp.prod);
  assign prod_sat = sat_prod(mul_rsp.prod);
  assign prod_hi  = mul_rsp.prod[PROD_W-1:DATA_W];
  assign prod_pos = !mul_rsp.prod[PROD_W-1] && (mul_rsp.prod != '0);

  always_comb begin
    if (!prod_pos) begin
      duty_d = '0;
    end else if (prod_hi >= DATA_W'(DUTY_LIMIT)) begin
      duty_d = DUTY_LIMIT;
    end else begin
      duty_d = prod_hi[DUTY_W-1:0];
    end
  end

  // Clamp: upper limit wins when the range is inverted.
  always_comb begin
    if (pre_q > cfg.level_max) begin
      lvl_d  = cfg.level_max;
      clip_d = 1'b1;
    end else if (pre_q < cfg.level_min) begin
      lvl_d  = cfg.level_min;
      clip_d = 1'b1;
    end else begin
      lvl_d  = pre_q;
      clip_d = 1'b0;
    end
  end

  // Sequencer: next state and multiplier operands.
  always_comb begin
    state_d   = state_q;
    mul_req.a = '0;
    mul_req.b = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_FB;
      end
      ST_FB: begin
        mul_req.a = {1'b0, cfg.feedback_scale};
        mul_req.b = {{(DATA_W-SAMPLE_W){1'b0}}, count_q};
        if (mul_rsp.done) state_d = ST_UP;
      end
      ST_UP: begin
        mul_req.a = cfg.prop_gain;
        mul_req.b = err_q;
        if (mul_rsp.done) state_d = ST_KI;
      end
      ST_KI: begin
        mul_req.a = cfg.integ_gain;
        mul_req.b = up_q;
        if (mul_rsp.done) state_d = ST_KC;
      end
      ST_KC: begin
        mul_req.a = cfg.windup_gain;
        mul_req.b = satd_q;
        if (mul_rsp.done) state_d = ST_KD;
      end
      ST_KD: begin
        mul_req.a = cfg.deriv_gain;
        mul_req.b = diff_q;
        if (mul_rsp.done) state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_DUTY;
      end
      ST_DUTY: begin
        mul_req.a = lvl_q;
        mul_req.b = {1'b0, cfg.duty_scale};
        if (mul_rsp.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // Issue one multiply on entry to each multiply step.
    go_d = (state_d != state_q) && (state_d != ST_IDLE) &&
           (state_d != ST_CLAMP) && (state_d != ST_FIN);
    mul_req.start = go_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
    end
  end

  // Controller state: integral, saturation difference, previous P term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      satd_q  <= '0;
      prev_q  <= '0;
    end else begin
      if ((state_q == ST_KI || state_q == ST_KC) && mul_rsp.done) begin
        integ_q <= sat_add(integ_q, prod_q16);
      end
      if (state_q == ST_CLAMP) begin
        satd_q <= sat_sub(lvl_d, pre_q);
        prev_q <= up_q;
      end
    end
  end

  // Per-item terms.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      target_q <= in_i.current_target;
      count_q  <= in_i.current_sample;
    end
    if (state_q == ST_FB && mul_rsp.done) begin
      err_q <= sat_sub(target_q, prod_sat);
    end
    if (state_q == ST_UP && mul_rsp.done) begin
      up_q <= prod_q16;
    end
    if (state_q == ST_KI && mul_rsp.done) begin
      diff_q <= sat_sub(up_q, prev_q);
    end
    // Integral is final once the correction step is done.
    if (state_q == ST_KD && go_q) begin
      s1_q <= sat_add(up_q, integ_q);
    end
    if (state_q == ST_KD && mul_rsp.done) begin
      pre_q <= sat_add(s1_q, prod_q16);
    end
    if (state_q == ST_CLAMP) begin
      lvl_q  <= lvl_d;
      clip_q <= clip_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      duty_q    <= duty_d;
      level_q   <= lvl_q;
      clamped_q <= clip_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.duty_count  = duty_q;
  assign res_o.drive_level = level_q;
  assign res_o.clamped     = clamped_q;

  `CPWA_ASSERT(a_accept_starts_fb, in_xfer |=> (state_q == ST_FB) && go_q, "transfer did not start feedback multiply")
  `CPWA_ASSERT(a_done_in_mul_step, mul_rsp.done |-> !go_q && mul_step, "multiplier result outside a multiply step")
  `CPWA_ASSERT(a_duty_capped, res_o.valid |-> (res_o.duty_count <= DUTY_LIMIT), "duty count above limit")
  `CPWA_ASSERT(a_duty_sign, (res_o.valid && res_o.duty_count != '0) |-> !res_o.drive_level[DATA_W-1], "nonzero duty from negative level")
  `CPWA_ASSERT(a_reset_idle, !$past(rst_ni) |-> in_i.ready && !res_o.valid, "not idle after reset")

endmodule

`default_nettype wire
